// File: rtl/bis_pkg.sv
// shared types and constants of the bilinear image scaler
`timescale 1ns / 1ps

package bis_pkg;

    localparam int FRAC_BITS = 12;
    localparam int POS_W     = 28;   // 12-bit coordinate times 16-bit Q4.12 step
    localparam int INT_W     = POS_W - FRAC_BITS;
    localparam int NBANKS    = 4;

    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [FRAC_BITS:0]   weight_t;
    typedef logic [1:0]           bank_t;     // {row parity, column parity}
    typedef logic [2:0]           cfg_idx_t;
    typedef logic                 cmd_t;

    localparam weight_t FRAC_ONE = weight_t'(13'd4096);

    localparam cfg_idx_t CFG_ROW_STEP    = 3'd0;
    localparam cfg_idx_t CFG_COL_STEP    = 3'd1;
    localparam cfg_idx_t CFG_SRC_ROWS    = 3'd2;
    localparam cfg_idx_t CFG_SRC_COLS    = 3'd3;
    localparam cfg_idx_t CFG_INTERP_MODE = 3'd4;

    localparam cmd_t CMD_WRITE = 1'b0;
    localparam cmd_t CMD_READ  = 1'b1;

    localparam logic MODE_BILINEAR = 1'b0;
    localparam logic MODE_NEAREST  = 1'b1;

endpackage

// File: rtl/bilinear_image_scaler.sv
// bilinear image scaler top level: config registers, address pipeline and blend
`timescale 1ns / 1ps

// Usage
//   item channel (item_valid / item_stall) carries cmd, row, col, channel, sample.
//   A write beat stores one source byte (if in range) and gives no result; a read beat gives
//   exactly one out_value beat on the result channel (result_valid / result_stall).
//   Config registers are written through cfg_valid / cfg_ready (always ready),
//   cfg_index selecting the register; write them only while the block is idle.
// Timing
//   A read result passes stages 1 to 5 and the output register. One item is
//   taken every cycle while item_stall is low: the four neighbours come from
//   four parity banks of the frame store in one read, and the blend is split
//   over two stages. A write reaches the store at the same pipeline stage where
//   reads sample it, so a read accepted after a write always sees the new byte.
// Reset and stall
//   rst_n clears the pipeline and loads the config defaults; the frame store is
//   not cleared and holds garbage until written. A stalled result holds its
//   value; the pipeline keeps filling its empty stages and raises item_stall
//   only once every stage holds an item.
module bilinear_image_scaler #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256,
    parameter int CHANNELS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 cmd,
    input  logic [11:0]          row,
    input  logic [11:0]          col,
    input  logic [1:0]           channel,
    input  logic [7:0]           sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [7:0]           out_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  bis_pkg::cfg_idx_t    cfg_index,
    input  logic [15:0]          cfg_data
);

    import bis_pkg::*;

    localparam int RW         = $clog2(MAX_ROWS);
    localparam int CW         = $clog2(MAX_COLS);
    localparam int HALF_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int HALF_COLS  = (MAX_COLS + 1) / 2;
    localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS * CHANNELS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // config registers
    logic [15:0] row_step_reg;
    logic [15:0] col_step_reg;
    logic [8:0]  src_rows_reg;
    logic [8:0]  src_cols_reg;
    logic        interp_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_step_reg    <= 16'd4096;
            col_step_reg    <= 16'd4096;
            src_rows_reg    <= 9'd256;
            src_cols_reg    <= 9'd256;
            interp_mode_reg <= MODE_BILINEAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROW_STEP:    row_step_reg    <= cfg_data;
                CFG_COL_STEP:    col_step_reg    <= cfg_data;
                CFG_SRC_ROWS:    src_rows_reg    <= cfg_data[8:0];
                CFG_SRC_COLS:    src_cols_reg    <= cfg_data[8:0];
                CFG_INTERP_MODE: interp_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // stage load enables, bubbles collapse toward the output
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic result_valid_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld_out;

    assign ld_out     = !result_valid_reg || !result_stall;
    assign ld5        = !s5_valid_reg || ld_out;
    assign ld4        = !s4_valid_reg || ld5;
    assign ld3        = !s3_valid_reg || ld4;
    assign ld2        = !s2_valid_reg || ld3;
    assign ld1        = !s1_valid_reg || ld2;
    assign item_stall = !ld1;

    // stage 1: source position products
    cmd_t              s1_cmd_reg;
    logic [11:0]       s1_row_reg, s1_col_reg;
    logic [1:0]        s1_chan_reg;
    logic [7:0]        s1_sample_reg;
    logic [POS_W-1:0]  s1_rpos_reg, s1_cpos_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_cmd_reg    <= cmd;
            s1_row_reg    <= row;
            s1_col_reg    <= col;
            s1_chan_reg   <= channel;
            s1_sample_reg <= sample;
            s1_rpos_reg   <= POS_W'(row) * POS_W'(row_step_reg);
            s1_cpos_reg   <= POS_W'(col) * POS_W'(col_step_reg);
        end
    end

    // stage 2: clamp to the image and pick neighbours
    logic [RW-1:0] last_row, r0_c, r1_c;
    logic [CW-1:0] last_col, c0_c, c1_c;
    logic [INT_W-1:0] rint, cint;
    frac_t fr_c, fc_c;

    logic [RW-1:0] s2_r0_next, s2_r1_next;
    logic [CW-1:0] s2_c0_next, s2_c1_next;
    frac_t         s2_fr_next, s2_fc_next;
    logic          s2_chan_ok_next, s2_wr_ok_next;
    logic [1:0]    s2_chan_next;

    logic [RW-1:0] s2_r0_reg, s2_r1_reg;
    logic [CW-1:0] s2_c0_reg, s2_c1_reg;
    frac_t         s2_fr_reg, s2_fc_reg;
    logic          s2_chan_ok_reg, s2_wr_ok_reg;
    logic [1:0]    s2_chan_reg;
    cmd_t          s2_cmd_reg;
    logic [7:0]    s2_sample_reg;

    always_comb
    begin
        if (src_rows_reg == 9'd0)
            last_row = '0;
        else if (32'(src_rows_reg) > MAX_ROWS)
            last_row = RW'(MAX_ROWS - 1);
        else
            last_row = RW'(src_rows_reg - 9'd1);

        if (src_cols_reg == 9'd0)
            last_col = '0;
        else if (32'(src_cols_reg) > MAX_COLS)
            last_col = CW'(MAX_COLS - 1);
        else
            last_col = CW'(src_cols_reg - 9'd1);

        rint = s1_rpos_reg[POS_W-1:FRAC_BITS];
        cint = s1_cpos_reg[POS_W-1:FRAC_BITS];
        fr_c = s1_rpos_reg[FRAC_BITS-1:0];
        fc_c = s1_cpos_reg[FRAC_BITS-1:0];

        r0_c = (32'(rint) > 32'(last_row)) ? last_row : RW'(rint);
        c0_c = (32'(cint) > 32'(last_col)) ? last_col : CW'(cint);
        r1_c = (r0_c != last_row) ? r0_c + RW'(1) : r0_c;
        c1_c = (c0_c != last_col) ? c0_c + CW'(1) : c0_c;

        s2_chan_ok_next = 32'(s1_chan_reg) < CHANNELS;
        s2_chan_next    = s2_chan_ok_next ? s1_chan_reg : 2'd0;
        s2_wr_ok_next   = (32'(s1_row_reg) < MAX_ROWS) && (32'(s1_col_reg) < MAX_COLS)
                          && s2_chan_ok_next;

        if (s1_cmd_reg == CMD_WRITE)
        begin
            // both neighbours point at the write target
            s2_r0_next = RW'(s1_row_reg);
            s2_r1_next = RW'(s1_row_reg);
            s2_c0_next = CW'(s1_col_reg);
            s2_c1_next = CW'(s1_col_reg);
            s2_fr_next = '0;
            s2_fc_next = '0;
        end
        else if (interp_mode_reg == MODE_NEAREST)
        begin
            // collapse to one sample with zero fractions, the blend passes it through
            s2_r0_next = fr_c[FRAC_BITS-1] ? r1_c : r0_c;
            s2_r1_next = s2_r0_next;
            s2_c0_next = fc_c[FRAC_BITS-1] ? c1_c : c0_c;
            s2_c1_next = s2_c0_next;
            s2_fr_next = '0;
            s2_fc_next = '0;
        end
        else
        begin
            s2_r0_next = r0_c;
            s2_r1_next = r1_c;
            s2_c0_next = c0_c;
            s2_c1_next = c1_c;
            s2_fr_next = fr_c;
            s2_fc_next = fc_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_r0_reg      <= s2_r0_next;
            s2_r1_reg      <= s2_r1_next;
            s2_c0_reg      <= s2_c0_next;
            s2_c1_reg      <= s2_c1_next;
            s2_fr_reg      <= s2_fr_next;
            s2_fc_reg      <= s2_fc_next;
            s2_chan_ok_reg <= s2_chan_ok_next;
            s2_wr_ok_reg   <= s2_wr_ok_next;
            s2_chan_reg    <= s2_chan_next;
            s2_cmd_reg     <= s1_cmd_reg;
            s2_sample_reg  <= s1_sample_reg;
        end
    end

    // stage 3: bank addresses
    logic [RW-1:0] bank_row [NBANKS];
    logic [CW-1:0] bank_col [NBANKS];
    logic [3:0][BANK_AW-1:0] s3_addr_next;
    logic [3:0][BANK_AW-1:0] s3_addr_reg;
    bank_t         s3_par_next;   // {r1 parity, c1 parity}

    logic          s3_r0p_reg, s3_r1p_reg, s3_c0p_reg, s3_c1p_reg;
    frac_t         s3_fr_reg, s3_fc_reg;
    logic          s3_chan_ok_reg, s3_wr_ok_reg;
    cmd_t          s3_cmd_reg;
    logic [7:0]    s3_sample_reg;

    always_comb
    begin
        for (int b = 0; b < NBANKS; b++)
        begin
            // each bank serves the neighbour row and column of its own parity
            bank_row[b] = (s2_r0_reg[0] == 1'(b >> 1)) ? s2_r0_reg : s2_r1_reg;
            bank_col[b] = (s2_c0_reg[0] == 1'(b & 1)) ? s2_c0_reg : s2_c1_reg;
            s3_addr_next[b] = BANK_AW'(((32'(bank_row[b]) >> 1) * HALF_COLS
                                        + (32'(bank_col[b]) >> 1)) * CHANNELS
                                       + 32'(s2_chan_reg));
        end
        s3_par_next = {s2_r1_reg[0], s2_c1_reg[0]};
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_addr_reg    <= s3_addr_next;
            s3_r0p_reg     <= s2_r0_reg[0];
            s3_c0p_reg     <= s2_c0_reg[0];
            s3_r1p_reg     <= s3_par_next[1];
            s3_c1p_reg     <= s3_par_next[0];
            s3_fr_reg      <= s2_fr_reg;
            s3_fc_reg      <= s2_fc_reg;
            s3_chan_ok_reg <= s2_chan_ok_reg;
            s3_wr_ok_reg   <= s2_wr_ok_reg;
            s3_cmd_reg     <= s2_cmd_reg;
            s3_sample_reg  <= s2_sample_reg;
        end
    end

    // stage 4: frame store access, writes land on the same edge reads sample
    logic [3:0][7:0] rd_data;
    logic            wr_en;

    assign wr_en = ld4 && s3_valid_reg && (s3_cmd_reg == CMD_WRITE) && s3_wr_ok_reg;

    bis_store #(
        .BANK_DEPTH (BANK_DEPTH),
        .BANK_AW    (BANK_AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (ld4),
        .rd_addr (s3_addr_reg),
        .wr_en   (wr_en),
        .wr_bank ({s3_r0p_reg, s3_c0p_reg}),
        .wr_addr (s3_addr_reg[{s3_r0p_reg, s3_c0p_reg}]),
        .wr_data (s3_sample_reg),
        .rd_data (rd_data)
    );

    logic   s4_r0p_reg, s4_r1p_reg, s4_c0p_reg, s4_c1p_reg;
    frac_t  s4_fr_reg, s4_fc_reg;
    logic   s4_chan_ok_reg;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_r0p_reg     <= s3_r0p_reg;
            s4_r1p_reg     <= s3_r1p_reg;
            s4_c0p_reg     <= s3_c0p_reg;
            s4_c1p_reg     <= s3_c1p_reg;
            s4_fr_reg      <= s3_fr_reg;
            s4_fc_reg      <= s3_fc_reg;
            s4_chan_ok_reg <= s3_chan_ok_reg;
        end
    end

    // stage 5: vertical blend of both neighbour columns
    logic [7:0]  s00, s10, s01, s11;
    weight_t     wr0, wr1;
    logic [20:0] v0_sum, v1_sum;
    logic [19:0] s5_v0_next, s5_v1_next;
    logic [19:0] s5_v0_reg, s5_v1_reg;
    frac_t       s5_fc_reg;
    logic        s5_chan_ok_reg;

    always_comb
    begin
        s00 = rd_data[{s4_r0p_reg, s4_c0p_reg}];
        s10 = rd_data[{s4_r1p_reg, s4_c0p_reg}];
        s01 = rd_data[{s4_r0p_reg, s4_c1p_reg}];
        s11 = rd_data[{s4_r1p_reg, s4_c1p_reg}];
        wr0 = FRAC_ONE - weight_t'(s4_fr_reg);
        wr1 = weight_t'(s4_fr_reg);
        v0_sum = 21'(s00) * 21'(wr0) + 21'(s10) * 21'(wr1);
        v1_sum = 21'(s01) * 21'(wr0) + 21'(s11) * 21'(wr1);
        s5_v0_next = v0_sum[19:0];
        s5_v1_next = v1_sum[19:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            s5_v0_reg      <= s5_v0_next;
            s5_v1_reg      <= s5_v1_next;
            s5_fc_reg      <= s4_fc_reg;
            s5_chan_ok_reg <= s4_chan_ok_reg;
        end
    end

    // output stage: horizontal blend, truncate to a byte
    weight_t     wc0, wc1;
    logic [31:0] blend_sum;
    logic [7:0]  out_value_next;
    logic [7:0]  out_value_reg;

    always_comb
    begin
        wc0 = FRAC_ONE - weight_t'(s5_fc_reg);
        wc1 = weight_t'(s5_fc_reg);
        blend_sum = 32'(s5_v0_reg) * 32'(wc0) + 32'(s5_v1_reg) * 32'(wc1);
        out_value_next = s5_chan_ok_reg ? blend_sum[31:24] : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_value_reg <= out_value_next;
        end
    end

    // valid bits, write beats leave the pipeline after the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)    s1_valid_reg     <= item_valid;
            if (ld2)    s2_valid_reg     <= s1_valid_reg;
            if (ld3)    s3_valid_reg     <= s2_valid_reg;
            if (ld4)    s4_valid_reg     <= s3_valid_reg && (s3_cmd_reg == CMD_READ);
            if (ld5)    s5_valid_reg     <= s4_valid_reg;
            if (ld_out) result_valid_reg <= s5_valid_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_value    = out_value_reg;

endmodule

// File: rtl/bis_store.sv
// source frame store split in four banks by row and column parity
`timescale 1ns / 1ps

module bis_store #(
    parameter int BANK_DEPTH = 49152,
    parameter int BANK_AW    = 16
) (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [3:0][BANK_AW-1:0]         rd_addr,
    input  logic                            wr_en,
    input  bis_pkg::bank_t                  wr_bank,
    input  logic [BANK_AW-1:0]              wr_addr,
    input  logic [7:0]                      wr_data,
    output logic [3:0][7:0]                 rd_data
);

    import bis_pkg::*;

    for (genvar b = 0; b < NBANKS; b++) begin : g_bank
        logic [7:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == bank_t'(b)))
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_data[b] <= mem[rd_addr[b]];
            end
        end
    end

endmodule

// File: sim/tb.sv
// self-checking bench for the bilinear image scaler, random and directed beats
`timescale 1ns / 1ps

module tb;
    import bis_pkg::*;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_COLS     = 256;
    localparam int CHANNELS     = 3;
    localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLS * CHANNELS;
    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 4000;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 50;

    localparam frac_t FRAC_HALF = frac_t'(1 << (FRAC_BITS - 1));

    typedef struct {
        cmd_t        cmd;
        logic [11:0] row;
        logic [11:0] col;
        logic [1:0]  channel;
        logic [7:0]  sample;
    } pixel_op_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        cmd = CMD_WRITE;
    logic [11:0] row = '0;
    logic [11:0] col = '0;
    logic [1:0]  channel = '0;
    logic [7:0]  sample = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  out_value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = CFG_ROW_STEP;
    logic [15:0] cfg_data = '0;

    // predictor copy of the frame store and registers
    logic [7:0]  frame_copy [STORE_DEPTH];
    logic [15:0] row_step_q = 16'd4096;
    logic [15:0] col_step_q = 16'd4096;
    logic [8:0]  src_rows_q = 9'd256;
    logic [8:0]  src_cols_q = 9'd256;
    logic        mode_q = MODE_BILINEAR;
    logic [7:0]  expected_pixels [$];

    // stimulus side: which store entries hold a written byte, and the settings in force
    bit          written_map [STORE_DEPTH];
    logic [15:0] gen_row_step = 16'd4096;
    logic [15:0] gen_col_step = 16'd4096;
    logic [8:0]  gen_src_rows = 9'd256;
    logic [8:0]  gen_src_cols = 9'd256;
    pixel_op_t   pending_items [$];

    logic        item_beat_taken = 1'b0;
    int          gap_pct = 15;
    int          stall_pct = 73;
    int          errors = 0;
    int          item_beats = 0;
    int          pixels_checked = 0;
    int          reg_writes = 0;
    int          quiet_cycles = 0;

    bilinear_image_scaler #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .CHANNELS(CHANNELS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .cmd(cmd),
        .row(row),
        .col(col),
        .channel(channel),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .out_value(out_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int dim_limit(input logic [8:0] n, input int max_n);
        if (n == 0) return 1;
        if (int'(n) > max_n) return max_n;
        return int'(n);
    endfunction

    function automatic int store_addr(input int r, input int c, input int ch);
        return (r * MAX_COLS + c) * CHANNELS + ch;
    endfunction

    function automatic bit in_store(input logic [11:0] r, input logic [11:0] c,
                                    input logic [1:0] ch);
        return int'(r) < MAX_ROWS && int'(c) < MAX_COLS && int'(ch) < CHANNELS;
    endfunction

    // source neighbours and fractions of a destination sample, clamped at the edges
    function automatic void locate(
        input  logic [11:0] drow,
        input  logic [11:0] dcol,
        input  logic [15:0] rstep,
        input  logic [15:0] cstep,
        input  logic [8:0]  nrows,
        input  logic [8:0]  ncols,
        output int          r0,
        output int          r1,
        output int          c0,
        output int          c1,
        output frac_t       fr,
        output frac_t       fc
    );
        logic [POS_W-1:0] rpos;
        logic [POS_W-1:0] cpos;
        int               rows;
        int               cols;
        rows = dim_limit(nrows, MAX_ROWS);
        cols = dim_limit(ncols, MAX_COLS);
        rpos = POS_W'(drow) * POS_W'(rstep);
        cpos = POS_W'(dcol) * POS_W'(cstep);
        r0 = int'(rpos >> FRAC_BITS);
        c0 = int'(cpos >> FRAC_BITS);
        fr = rpos[FRAC_BITS-1:0];
        fc = cpos[FRAC_BITS-1:0];
        if (r0 > rows - 1) r0 = rows - 1;
        if (c0 > cols - 1) c0 = cols - 1;
        r1 = (r0 + 1 < rows) ? r0 + 1 : r0;
        c1 = (c0 + 1 < cols) ? c0 + 1 : c0;
    endfunction

    function automatic logic [7:0] scaled_pixel(input logic [11:0] drow, input logic [11:0] dcol,
                                                input logic [1:0] ch);
        int              r0, r1, c0, c1, rs, cs;
        frac_t           fr, fc;
        weight_t         wr0, wr1, wc0, wc1;
        longint unsigned p00, p10, p01, p11, acc;
        if (int'(ch) >= CHANNELS) return 8'd0;
        locate(drow, dcol, row_step_q, col_step_q, src_rows_q, src_cols_q,
               r0, r1, c0, c1, fr, fc);
        if (mode_q == MODE_NEAREST) begin
            rs = (fr >= FRAC_HALF) ? r1 : r0;
            cs = (fc >= FRAC_HALF) ? c1 : c0;
            return frame_copy[store_addr(rs, cs, int'(ch))];
        end
        wr1 = weight_t'(fr);
        wr0 = FRAC_ONE - wr1;
        wc1 = weight_t'(fc);
        wc0 = FRAC_ONE - wc1;
        p00 = frame_copy[store_addr(r0, c0, int'(ch))];
        p10 = frame_copy[store_addr(r1, c0, int'(ch))];
        p01 = frame_copy[store_addr(r0, c1, int'(ch))];
        p11 = frame_copy[store_addr(r1, c1, int'(ch))];
        acc = p00 * wr0 * wc0 + p10 * wr1 * wc0 + p01 * wr0 * wc1 + p11 * wr1 * wc1;
        return 8'(acc >> (2 * FRAC_BITS));
    endfunction

    // reads of a real channel are sent only where all four neighbours hold written bytes
    function automatic bit read_is_safe(input logic [11:0] drow, input logic [11:0] dcol,
                                        input logic [1:0] ch);
        int    r0, r1, c0, c1;
        frac_t fr, fc;
        if (int'(ch) >= CHANNELS) return 1'b1;
        locate(drow, dcol, gen_row_step, gen_col_step, gen_src_rows, gen_src_cols,
               r0, r1, c0, c1, fr, fc);
        return written_map[store_addr(r0, c0, int'(ch))] && written_map[store_addr(r1, c0, int'(ch))]
            && written_map[store_addr(r0, c1, int'(ch))] && written_map[store_addr(r1, c1, int'(ch))];
    endfunction

    // destination coordinate that lands on source line tgt, random fraction
    function automatic int aim_coord(input int tgt, input logic [15:0] step);
        int d;
        if (step == 0) return $urandom_range(0, 4095);
        d = ((tgt << FRAC_BITS) + $urandom_range(0, (1 << FRAC_BITS) - 1)) / int'(step);
        return (d > 4095) ? 4095 : d;
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd4096;
            3:       return 16'd2048;
            4:       return 16'(4096 + $urandom_range(0, 8191));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [8:0] pick_big_dim();
        case ($urandom_range(0, 2))
            0:       return 9'd256;
            1:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(5, 255));
        endcase
    endfunction

    task automatic queue_op(input cmd_t op, input int r, input int c, input int ch,
                            input int smp);
        pixel_op_t it;
        it.cmd     = op;
        it.row     = 12'(r);
        it.col     = 12'(c);
        it.channel = 2'(ch);
        it.sample  = 8'(smp);
        if (op == CMD_WRITE && in_store(it.row, it.col, it.channel))
            written_map[store_addr(r, c, ch)] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic queue_read(input int top_r, input int top_c, input int hgt, input int wid);
        int dr, dc, ch;
        bit found;
        found = 1'b0;
        dr = 0;
        dc = 0;
        ch = $urandom_range(0, CHANNELS - 1);
        for (int t = 0; t < 40 && !found; t++) begin
            if ($urandom_range(0, 1)) begin
                dr = aim_coord(top_r + $urandom_range(0, (hgt > 1) ? hgt - 2 : 0), gen_row_step);
                dc = aim_coord(top_c + $urandom_range(0, (wid > 1) ? wid - 2 : 0), gen_col_step);
            end
            else if ($urandom_range(0, 1)) begin
                dr = $urandom_range(0, 31);
                dc = $urandom_range(0, 31);
            end
            else begin
                dr = $urandom_range(0, 4095);
                dc = $urandom_range(0, 4095);
            end
            found = read_is_safe(12'(dr), 12'(dc), 2'(ch));
        end
        // the origin square is always written
        if (!found) begin
            dr = 0;
            dc = 0;
        end
        queue_op(CMD_READ, dr, dc, ch, $urandom_range(0, 255));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] rs, input logic [15:0] cs,
                              input logic [8:0] nr, input logic [8:0] nc, input logic md);
        write_reg(CFG_ROW_STEP, rs);
        write_reg(CFG_COL_STEP, cs);
        write_reg(CFG_SRC_ROWS, 16'(nr));
        write_reg(CFG_SRC_COLS, 16'(nc));
        write_reg(CFG_INTERP_MODE, 16'(md));
        gen_row_step = rs;
        gen_col_step = cs;
        gen_src_rows = nr;
        gen_src_cols = nc;
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // even phases scale a tiny image written whole, odd ones a large image with a written patch
    task automatic run_phase(input int p);
        logic [15:0] rs, cs;
        logic [8:0]  nr, nc;
        logic        md;
        bit          big;
        int          rows, cols, pr, pc, ph, pw, sel;
        big = (p % 2) == 1;
        rs = (p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF : pick_step();
        cs = (p == 0) ? 16'hFFFF : (p == 1) ? 16'd0 : pick_step();
        md = (p == 0) ? MODE_NEAREST : (p == 1) ? MODE_BILINEAR : 1'($urandom_range(0, 1));
        if (big) begin
            nr = (p == 1) ? 9'd511 : pick_big_dim();
            nc = (p == 1) ? 9'd256 : pick_big_dim();
        end
        else begin
            nr = (p == 0) ? 9'd0 : 9'($urandom_range(1, 4));
            nc = (p == 0) ? 9'd4 : 9'($urandom_range(0, 4));
        end
        wait_idle();
        set_config(rs, cs, nr, nc, md);
        rows = dim_limit(nr, MAX_ROWS);
        cols = dim_limit(nc, MAX_COLS);
        ph = (big && rows > 3) ? 3 : rows;
        pw = (big && cols > 3) ? 3 : cols;
        pr = $urandom_range(0, 1) ? rows - ph : $urandom_range(0, rows - ph);
        pc = $urandom_range(0, 1) ? cols - pw : $urandom_range(0, cols - pw);
        for (int r = 0; r < ph; r++)
            for (int c = 0; c < pw; c++)
                for (int ch = 0; ch < CHANNELS; ch++)
                    queue_op(CMD_WRITE, pr + r, pc + c, ch, $urandom_range(0, 255));
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                queue_read(pr, pc, ph, pw);
            else if (sel < 85)
                queue_op(CMD_WRITE, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                         $urandom_range(0, CHANNELS - 1), $urandom_range(0, 255));
            else if (sel < 93)
                queue_op(CMD_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 3), $urandom_range(0, 255));
            else
                queue_op(CMD_READ, $urandom_range(0, 4095), $urandom_range(0, 4095), 3,
                         $urandom_range(0, 255));
        end
    endtask

    // item driver: a presented beat holds until taken
    always @(negedge clk)
    begin
        pixel_op_t nxt;
        if (rst_n) begin
            result_stall <= ($urandom_range(0, 99) < stall_pct);
            if (!item_valid || item_beat_taken) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    nxt = pending_items.pop_front();
                    item_valid <= 1'b1;
                    cmd        <= nxt.cmd;
                    row        <= nxt.row;
                    col        <= nxt.col;
                    channel    <= nxt.channel;
                    sample     <= nxt.sample;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on item beats, checks result beats, tracks register writes
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n) begin
            item_beat_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall) begin
                item_beats++;
                if (cmd == CMD_READ)
                    expected_pixels.push_back(scaled_pixel(row, col, channel));
                else if (in_store(row, col, channel))
                    frame_copy[store_addr(row, col, channel)] = sample;
            end
            if (result_valid && !result_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("out_value beat with nothing expected: actual 0x%02h", out_value);
                    errors++;
                end
                else begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (out_value !== want) begin
                        $error("out_value mismatch: expected 0x%02h, actual 0x%02h",
                               want, out_value);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_index)
                    CFG_ROW_STEP:    row_step_q = cfg_data;
                    CFG_COL_STEP:    col_step_q = cfg_data;
                    CFG_SRC_ROWS:    src_rows_q = cfg_data[8:0];
                    CFG_SRC_COLS:    src_cols_q = cfg_data[8:0];
                    CFG_INTERP_MODE: mode_q = cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int idx;
        idx = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset settings: one-to-one scale, zero fractions give the base byte
        queue_op(CMD_WRITE, 0, 0, 0, 8'hFF);
        queue_op(CMD_WRITE, 0, 1, 0, 8'h00);
        queue_op(CMD_WRITE, 1, 0, 0, 8'hAA);
        queue_op(CMD_WRITE, 1, 1, 0, 8'h55);
        queue_op(CMD_READ, 0, 0, 0, 8'h00);
        wait_idle();

        // 2x2 image, steps 1.5 and 0.5
        set_config(16'h1800, 16'h0800, 9'd2, 9'd2, MODE_BILINEAR);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    queue_op(CMD_WRITE, r, c, ch,
                             (idx == 0) ? 8'hFF : (idx == 1) ? 8'h00 : $urandom_range(0, 255));
                    idx++;
                end
        queue_op(CMD_WRITE, 4095, 4095, 3, 8'hFF);
        queue_op(CMD_WRITE, 256, 0, 0, 8'h12);
        queue_op(CMD_WRITE, 0, 256, 1, 8'h34);
        queue_op(CMD_READ, 0, 0, 0, 8'h00);
        queue_op(CMD_READ, 1, 1, 1, 8'hFF);     // both fractions exactly one half
        queue_op(CMD_READ, 4095, 4095, 2, 8'h00);
        queue_op(CMD_READ, 4095, 0, 0, 8'h00);
        queue_op(CMD_READ, 0, 0, 3, 8'hFF);     // no such channel, reads zero

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 4) begin
                gap_pct   = 73;
                stall_pct = 15;
            end
            if (p == 7) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            run_phase(p);
        end
        wait_idle();

        $display("covered %0d item beats and %0d scaled samples over %0d settings",
                 item_beats, pixels_checked, NUM_PHASES + 2);
        $display("%0d register writes, %0d mismatches", reg_writes, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: bilinear_image_scaler.f
rtl/bis_pkg.sv
rtl/bis_store.sv
rtl/bilinear_image_scaler.sv
sim/tb.sv
